@@ rtl/core/bptc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants of the barometric temperature and pressure
// compensation pipeline: payload structs, calibration set, status codes.
// ----------------------------------------------------------------------------
package bptc_pkg;

	// Input item: one raw reading pair
	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [18:0] raw_pressure;
	} sample_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIV_ZERO  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	// Result item
	typedef struct packed {
		logic signed [15:0] temperature_tenths;
		logic        [18:0] pressure_pa;
		status_t            status;
	} result_t;

	// Unpacked calibration coefficients
	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic        [15:0] ac4;
		logic        [15:0] ac5;
		logic        [15:0] ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic        [1:0]  oss;
	} cal_t;

	// Sideband riding along the temperature divider
	typedef struct packed {
		logic signed [18:0] x1;
		logic               neg;
		logic               zero;
		logic        [18:0] up;
	} tside_t;

	// Sideband riding along the pressure divider
	typedef struct packed {
		logic signed [15:0] temp;
		logic               zero;
		logic               big;
	} pside_t;

	// Configuration register indexes
	localparam logic [2:0] REG_AC1_AC2  = 3'd0;
	localparam logic [2:0] REG_AC3_AC4  = 3'd1;
	localparam logic [2:0] REG_AC5_AC6  = 3'd2;
	localparam logic [2:0] REG_B1_B2    = 3'd3;
	localparam logic [2:0] REG_MC_MD    = 3'd4;
	localparam logic [2:0] REG_OSS      = 3'd5;

	// Divider geometry
	localparam int TDIV_NUM_W = 27;
	localparam int TDIV_DEN_W = 20;
	localparam int PDIV_NUM_W = 32;
	localparam int PDIV_DEN_W = 33;

	// Compensation constants
	localparam logic [11:0] B6_OFS   = 12'd4000;
	localparam logic [15:0] B7_SCALE = 16'd50000;
	localparam logic [31:0] B4_BIAS  = 32'd32768;
	localparam logic [11:0] P_SQ_K   = 12'd3038;
	localparam logic [12:0] P_LIN_K  = 13'd7357;
	localparam logic [11:0] P_OFS    = 12'd3791;
	localparam logic [18:0] P_MAX    = 19'h7FFFF;

endpackage
`default_nettype wire

@@ rtl/core/bptc_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_div_pipe
// Unsigned restoring divider, one quotient bit per register stage, with a
// sideband word carried along. Takes new operands each cycle that en is high.
// ----------------------------------------------------------------------------
module bptc_div_pipe #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 33,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [DEN_W-1:0]  in_den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_vld,
	output logic [NUM_W-1:0]       out_quo,
	output logic [SIDE_W-1:0]      out_side
);

	logic              vld_s  [NUM_W];
	logic [NUM_W-1:0]  num_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W-1];
	logic [DEN_W-1:0]  den_s  [NUM_W-1];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              vld_in;
		logic [DEN_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [NUM_W-1:0]  num_in;
		logic [SIDE_W-1:0] side_in;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              bit_q;

		// Select the previous stage or the operand inputs
		if (i == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign den_in  = in_den;
			assign num_in  = in_num;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign num_in  = num_s[i-1];
			assign side_in = side_s[i-1];
		end

		// Shift in the next dividend bit and try the subtract
		assign trial = {rem_in, num_in[NUM_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign bit_q = ~diff[DEN_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i]  <= {num_in[NUM_W-2:0], bit_q};
				side_s[i] <= side_in;
			end
		end

		// Carry remainder and divisor to the next stage
		if (i < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= bit_q ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign out_vld  = vld_s[NUM_W-1];
	assign out_quo  = num_s[NUM_W-1];
	assign out_side = side_s[NUM_W-1];

endmodule
`default_nettype wire

@@ rtl/core/bptc_coef.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_coef
// Stages between the two dividers: temperature result, then the B3 and B4
// terms and the scaled pressure difference B7 for the pressure divider.
// ----------------------------------------------------------------------------
module bptc_coef
	import bptc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire cal_t                  cal,
	input  wire logic                  in_vld,
	input  wire logic [TDIV_NUM_W-1:0] in_quo,
	input  wire tside_t                in_side,
	output logic                       out_vld,
	output logic [PDIV_NUM_W-1:0]      out_num,
	output logic [PDIV_DEN_W-1:0]      out_den,
	output pside_t                     out_side
);

	logic signed [15:0] ac1, ac2, ac3, b1, b2;
	assign ac1 = cal.ac1;
	assign ac2 = cal.ac2;
	assign ac3 = cal.ac3;
	assign b1  = cal.b1;
	assign b2  = cal.b2;

	// Stage 1: signed quotient, B5, temperature, B6
	logic signed [27:0] x2_c, b5_c, tr_c, b6_c;
	logic signed [15:0] t_c;
	logic               vld_s1, zero_s1;
	logic signed [27:0] b6_s1;
	logic signed [15:0] t_s1;
	logic        [18:0] up_s1;

	always_comb begin
		x2_c = in_side.neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
		b5_c = x2_c + 28'(in_side.x1);
		tr_c = (b5_c + 28'sd8) >>> 4;
		b6_c = b5_c - 28'($signed({1'b0, B6_OFS}));
		// Clamp temperature to 16 bits
		if (tr_c[27] && !(&tr_c[26:15])) begin
			t_c = 16'sh8000;
		end else if (!tr_c[27] && (|tr_c[26:15])) begin
			t_c = 16'sh7FFF;
		end else begin
			t_c = tr_c[15:0];
		end
	end

	// Stage 2: B6 squared and the two B6 products
	logic signed [55:0] sq_c;
	logic signed [43:0] ac2b6_c, ac3b6_c;
	logic               vld_s2, zero_s2;
	logic        [55:0] sq_s2;
	logic signed [43:0] ac2b6_s2, ac3b6_s2;
	logic signed [15:0] t_s2;
	logic        [18:0] up_s2;

	assign sq_c    = 56'(b6_s1) * 56'(b6_s1);
	assign ac2b6_c = 44'(ac2) * 44'(b6_s1);
	assign ac3b6_c = 44'(ac3) * 44'(b6_s1);

	// Stage 3: coefficient products on the scaled square
	logic signed [44:0] sqs_c;
	logic signed [60:0] b2sq_c, b1sq_c;
	logic               vld_s3, zero_s3;
	logic signed [60:0] b2sq_s3, b1sq_s3;
	logic signed [32:0] x2a_s3;
	logic signed [30:0] x1c_s3;
	logic signed [15:0] t_s3;
	logic        [18:0] up_s3;

	assign sqs_c  = $signed({1'b0, sq_s2[55:12]});
	assign b2sq_c = 61'(b2) * 61'(sqs_c);
	assign b1sq_c = 61'(b1) * 61'(sqs_c);

	// Stage 4: B3 before the oversampling shift, B4 operand
	logic signed [49:0] x1_c;
	logic signed [44:0] x2c_c;
	logic signed [45:0] x3s_c;
	logic        [33:0] b3pre_c;
	logic               vld_s4, zero_s4;
	logic        [33:0] b3pre_s4;
	logic        [31:0] u32_s4;
	logic signed [15:0] t_s4;
	logic        [18:0] up_s4;

	assign x1_c    = b2sq_s3[60:11];
	assign x2c_c   = b1sq_s3[60:16];
	assign b3pre_c = x1_c[33:0] + 34'(x2a_s3) + (34'(ac1) << 2);
	assign x3s_c   = 46'(x1c_s3) + 46'(x2c_c) + 46'sd2;

	// Stage 5: B3 and B4
	logic        [33:0] b3w_c;
	logic        [47:0] b4p_c;
	logic               vld_s5, zero_s5;
	logic        [31:0] b3_s5;
	logic        [32:0] b4_s5;
	logic signed [15:0] t_s5;
	logic        [18:0] up_s5;

	assign b3w_c = (b3pre_s4 << cal.oss) + 34'd2;
	assign b4p_c = 48'(cal.ac4) * 48'(u32_s4);

	// Stage 6: B7 and divide-by-zero status
	logic        [31:0] diff_c, b7_c;
	logic        [15:0] scale_c;
	logic               vld_s6, zero_s6;
	logic        [31:0] b7_s6;
	logic        [32:0] b4_s6;
	logic signed [15:0] t_s6;

	assign scale_c = B7_SCALE >> cal.oss;
	assign diff_c  = {13'd0, up_s5} - b3_s5;
	assign b7_c    = diff_c * {16'd0, scale_c};

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			b6_s1    <= b6_c;
			t_s1     <= t_c;
			zero_s1  <= in_side.zero;
			up_s1    <= in_side.up;

			sq_s2    <= sq_c;
			ac2b6_s2 <= ac2b6_c;
			ac3b6_s2 <= ac3b6_c;
			t_s2     <= t_s1;
			zero_s2  <= zero_s1;
			up_s2    <= up_s1;

			b2sq_s3  <= b2sq_c;
			b1sq_s3  <= b1sq_c;
			x2a_s3   <= ac2b6_s2[43:11];
			x1c_s3   <= ac3b6_s2[43:13];
			t_s3     <= t_s2;
			zero_s3  <= zero_s2;
			up_s3    <= up_s2;

			b3pre_s4 <= b3pre_c;
			u32_s4   <= x3s_c[33:2] + B4_BIAS;
			t_s4     <= t_s3;
			zero_s4  <= zero_s3;
			up_s4    <= up_s3;

			b3_s5    <= b3w_c[33:2];
			b4_s5    <= b4p_c[47:15];
			t_s5     <= t_s4;
			zero_s5  <= zero_s4;
			up_s5    <= up_s4;

			b7_s6    <= b7_c;
			b4_s6    <= b4_s5;
			t_s6     <= t_s5;
			zero_s6  <= zero_s5 | (b4_s5 == '0);
		end
	end

	// Double B7 before the divide unless its top bit is set
	assign out_vld       = vld_s6;
	assign out_num       = b7_s6[31] ? b7_s6 : {b7_s6[30:0], 1'b0};
	assign out_den       = b4_s6;
	assign out_side.temp = t_s6;
	assign out_side.zero = zero_s6;
	assign out_side.big  = b7_s6[31];

endmodule
`default_nettype wire

@@ rtl/core/bptc_finish.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bptc_finish
// Stages after the pressure divider: second-order pressure correction,
// range clamp and status encoding into the result item.
// ----------------------------------------------------------------------------
module bptc_finish
	import bptc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_vld,
	input  wire logic [PDIV_NUM_W-1:0] in_quo,
	input  wire pside_t                in_side,
	output logic                       out_vld,
	output result_t                    out_res
);

	// Stage 1: pressure estimate, its square and linear term
	logic        [32:0] p_c;
	logic               vld_s1, zero_s1;
	logic        [32:0] p_s1;
	logic        [49:0] sq_s1;
	logic        [45:0] m_s1;
	logic signed [15:0] t_s1;

	assign p_c = in_side.big ? {in_quo, 1'b0} : {1'b0, in_quo};

	// Stage 2: scaled correction terms
	logic        [61:0] x1p_c;
	logic signed [46:0] nm_c;
	logic               vld_s2, zero_s2;
	logic        [32:0] p_s2;
	logic        [45:0] x1_s2;
	logic signed [30:0] x2_s2;
	logic signed [15:0] t_s2;

	assign x1p_c = 62'(sq_s1) * 62'(P_SQ_K);
	assign nm_c  = -$signed({1'b0, m_s1});

	// Stage 3: corrected pressure
	logic signed [47:0] s_c, pf_c;
	logic               vld_s3, zero_s3;
	logic signed [47:0] pf_s3;
	logic signed [15:0] t_s3;

	assign s_c  = 48'($signed({1'b0, x1_s2})) + 48'(x2_s2)
		+ 48'($signed({1'b0, P_OFS}));
	assign pf_c = 48'($signed({1'b0, p_s2})) + (s_c >>> 4);

	// Stage 4: clamp and encode status
	result_t            res_c;
	logic               vld_s4;
	result_t            res_s4;

	always_comb begin
		res_c.temperature_tenths = t_s3;
		res_c.status             = ST_OK;
		if (pf_s3[47]) begin
			res_c.pressure_pa = '0;
			res_c.status      = ST_SATURATED;
		end else if (|pf_s3[46:19]) begin
			res_c.pressure_pa = P_MAX;
			res_c.status      = ST_SATURATED;
		end else begin
			res_c.pressure_pa = pf_s3[18:0];
		end
		// Zero divisor overrides everything
		if (zero_s3) begin
			res_c.temperature_tenths = '0;
			res_c.pressure_pa        = '0;
			res_c.status             = ST_DIV_ZERO;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_c;
			sq_s1   <= 50'(p_c[32:8]) * 50'(p_c[32:8]);
			m_s1    <= 46'(p_c) * 46'(P_LIN_K);
			t_s1    <= in_side.temp;
			zero_s1 <= in_side.zero;

			p_s2    <= p_s1;
			x1_s2   <= x1p_c[61:16];
			x2_s2   <= nm_c[46:16];
			t_s2    <= t_s1;
			zero_s2 <= zero_s1;

			pf_s3   <= pf_c;
			t_s3    <= t_s2;
			zero_s3 <= zero_s2;

			res_s4  <= res_c;
		end
	end

	assign out_vld = vld_s4;
	assign out_res = res_s4;

endmodule
`default_nettype wire

@@ rtl/core/baro_temp_pressure_compensation.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a digital barometer.
// ----------------------------------------------------------------------------
// Usage:
//   Load the five calibration words and the oversampling setting through the
//   write port (cfg_we, cfg_index, cfg_wdata) while no reading is in flight.
//   Present raw reading pairs on sample/sample_valid; one transfer occurs
//   when sample_valid and sample_ready are both high. Results leave on
//   result/result_valid with result_ready.
//   Throughput: one reading pair per cycle while sample_ready is high.
//   Depth: 72 register stages, set by the two restoring dividers, one
//   quotient bit per stage (27 stages for temperature, 32 for pressure),
//   plus 13 arithmetic and output stages.
//   Reset clears all valid bits and sets every calibration register to zero.
//   When the receiver stalls, a two-entry output buffer absorbs one more
//   result; sample_ready then drops and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation
	import bptc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        sample_valid,
	output logic             sample_ready,
	input  wire sample_t     sample,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result
);

	// Calibration registers
	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC1_AC2: begin
					cal_q.ac1 <= cfg_wdata[31:16];
					cal_q.ac2 <= cfg_wdata[15:0];
				end
				REG_AC3_AC4: begin
					cal_q.ac3 <= cfg_wdata[31:16];
					cal_q.ac4 <= cfg_wdata[15:0];
				end
				REG_AC5_AC6: begin
					cal_q.ac5 <= cfg_wdata[31:16];
					cal_q.ac6 <= cfg_wdata[15:0];
				end
				REG_B1_B2: begin
					cal_q.b1 <= cfg_wdata[31:16];
					cal_q.b2 <= cfg_wdata[15:0];
				end
				REG_MC_MD: begin
					cal_q.mc <= cfg_wdata[31:16];
					cal_q.md <= cfg_wdata[15:0];
				end
				REG_OSS: begin
					cal_q.oss <= cfg_wdata[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic en;
	logic skd_vld_q;

	// Pipeline advances while the output buffer has room
	assign en           = !skd_vld_q;
	assign sample_ready = en;

	logic signed [15:0] mc, md;
	assign mc = cal_q.mc;
	assign md = cal_q.md;

	// Stage 1: (UT - AC6) * AC5
	logic signed [16:0] d_c;
	logic               vld_s1;
	logic signed [33:0] prod_s1;
	logic        [18:0] up_s1;

	assign d_c = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, cal_q.ac6});

	// Stage 2: X1, temperature divisor, operand magnitudes
	logic signed [18:0] x1_c;
	logic signed [19:0] den_c;
	logic        [15:0] mcmag_c;
	logic               vld_s2;
	logic        [TDIV_NUM_W-1:0] num_s2;
	logic        [TDIV_DEN_W-1:0] den_s2;
	tside_t             side_s2;

	assign x1_c    = prod_s1[33:15];
	assign den_c   = 20'(x1_c) + 20'(md);
	assign mcmag_c = mc[15] ? 16'(-mc) : mc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1      <= 34'(d_c) * 34'($signed({1'b0, cal_q.ac5}));
			up_s1        <= sample.raw_pressure;
			num_s2       <= {mcmag_c, 11'd0};
			den_s2       <= den_c[19] ? 20'(-den_c) : den_c;
			side_s2.x1   <= x1_c;
			side_s2.neg  <= mc[15] ^ den_c[19];
			side_s2.zero <= (den_c == '0);
			side_s2.up   <= up_s1;
		end
	end

	// Temperature divider
	logic                  tdv_vld;
	logic [TDIV_NUM_W-1:0] tdv_quo;
	tside_t                tdv_side;

	bptc_div_pipe #(
		.NUM_W  (TDIV_NUM_W),
		.DEN_W  (TDIV_DEN_W),
		.SIDE_W ($bits(tside_t))
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_num   (num_s2),
		.in_den   (den_s2),
		.in_side  (side_s2),
		.out_vld  (tdv_vld),
		.out_quo  (tdv_quo),
		.out_side (tdv_side)
	);

	// Coefficient stages
	logic                  cf_vld;
	logic [PDIV_NUM_W-1:0] cf_num;
	logic [PDIV_DEN_W-1:0] cf_den;
	pside_t                cf_side;

	bptc_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cal      (cal_q),
		.in_vld   (tdv_vld),
		.in_quo   (tdv_quo),
		.in_side  (tdv_side),
		.out_vld  (cf_vld),
		.out_num  (cf_num),
		.out_den  (cf_den),
		.out_side (cf_side)
	);

	// Pressure divider
	logic                  pdv_vld;
	logic [PDIV_NUM_W-1:0] pdv_quo;
	pside_t                pdv_side;

	bptc_div_pipe #(
		.NUM_W  (PDIV_NUM_W),
		.DEN_W  (PDIV_DEN_W),
		.SIDE_W ($bits(pside_t))
	) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (cf_vld),
		.in_num   (cf_num),
		.in_den   (cf_den),
		.in_side  (cf_side),
		.out_vld  (pdv_vld),
		.out_quo  (pdv_quo),
		.out_side (pdv_side)
	);

	// Correction and clamp stages
	logic    fin_vld;
	result_t fin_res;

	bptc_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (pdv_vld),
		.in_quo  (pdv_quo),
		.in_side (pdv_side),
		.out_vld (fin_vld),
		.out_res (fin_res)
	);

	// Two-entry output buffer: output register plus skid entry
	logic    res_vld_q;
	result_t res_q;
	result_t skd_q;
	logic    push;
	logic    pop;

	assign push = en && fin_vld;
	assign pop  = res_vld_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (!res_vld_q || pop) begin
			if (skd_vld_q) begin
				res_vld_q <= 1'b1;
				skd_vld_q <= 1'b0;
			end else begin
				res_vld_q <= push;
			end
		end else if (push) begin
			skd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_vld_q || pop) begin
			res_q <= skd_vld_q ? skd_q : fin_res;
		end else if (push) begin
			skd_q <= fin_res;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	// Skid entry is only occupied behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> res_vld_q)
		else $error("skid entry holds data while output register is empty");

	// A held skid entry stays until the output moves
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q && !result_ready |=> skd_vld_q)
		else $error("skid entry dropped without a transfer");

	// Divide-by-zero results carry zero values
	a_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_DIV_ZERO)
		|-> (result.temperature_tenths == '0) && (result.pressure_pa == '0))
		else $error("divide-by-zero result with nonzero values");

	// Saturated pressure sits on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_SATURATED)
		|-> (result.pressure_pa == '0) || (result.pressure_pa == P_MAX))
		else $error("saturated pressure not on a range bound");
`endif

endmodule
`default_nettype wire
